@@ rtl/sfl_pkg.sv @@
// Shared constants, types and sine table builder for the stereo flanger.
`timescale 1ns / 1ps

package sfl_pkg;

   localparam int DELAY_DEPTH = 4096;  // power of two
   localparam int ADDR_W      = $clog2(DELAY_DEPTH);
   localparam int FILL_W      = ADDR_W + 1;

   localparam int SINE_SIZE   = 1024;  // power of two, at least 64
   localparam int SINE_IDX_W  = $clog2(SINE_SIZE);
   localparam int QTR_SHIFT   = SINE_IDX_W - 2;
   localparam int SINE_W      = 16;
   localparam int SINE_FRAC   = 15;

   localparam int SAMPLE_W    = 16;
   localparam int DELAY_W     = 10;
   localparam int GAIN_W      = 16;
   localparam int GAIN_FRAC   = 14;
   localparam int PHASE_W     = 32;
   localparam int WARM_W      = 13;

   localparam int MUL_W       = 17;
   localparam int PROD_W      = 2 * MUL_W;

   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_DELAY = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MOD_RANGE  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_MIX_GAIN   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP = CSR_IDX_W'(3);

   localparam logic [DELAY_W-1:0]       RST_BASE_DELAY = DELAY_W'(1000);
   localparam logic [DELAY_W-1:0]       RST_MOD_RANGE  = DELAY_W'(500);
   localparam logic signed [GAIN_W-1:0] RST_MIX_GAIN   = GAIN_W'(16384);
   localparam logic [PHASE_W-1:0]       RST_PHASE_STEP = PHASE_W'(19478);

   typedef struct packed {
      logic                       en;
      logic [ADDR_W-1:0]          addr;
      logic signed [SAMPLE_W-1:0] data;
   } mem_wr_type;

   typedef logic signed [SINE_W-1:0] sine_rom_type [SINE_SIZE];

   // Quarter-wave Taylor sine, Q30 with truncation, scaled to Q1.15.
   function automatic logic signed [SINE_W-1:0] sine_entry(input logic [SINE_IDX_W-1:0] k);
      logic [1:0]              quad;
      logic [SINE_IDX_W-1:0]   r;
      logic [63:0]             x;
      logic [63:0]             x2;
      logic [63:0]             p;
      logic [63:0]             y;
      logic [63:0]             s;
      logic signed [SINE_W-1:0] ent;
      quad = k[SINE_IDX_W-1 -: 2];
      r    = SINE_IDX_W'(k[QTR_SHIFT-1:0]);
      if (quad == 2'd1 || quad == 2'd3) begin
         r = SINE_IDX_W'((SINE_SIZE / 4)) - r;
      end
      x  = 64'(r) << (30 - QTR_SHIFT);
      x2 = (x * x) >> 30;
      p  = 64'd172272;
      p  = 64'd5026995    - ((x2 * p) >> 30);
      p  = 64'd85569306   - ((x2 * p) >> 30);
      p  = 64'd693598668  - ((x2 * p) >> 30);
      p  = 64'd1686629713 - ((x2 * p) >> 30);
      y  = (x * p) >> 30;
      s  = (y * 64'd32767 + 64'd536870912) >> 30;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      ent = SINE_W'(s);
      if (quad[1]) begin
         ent = -ent;
      end
      return ent;
   endfunction

   function automatic sine_rom_type sine_table();
      sine_rom_type t;
      for (int i = 0; i < SINE_SIZE; i++) begin
         t[i] = sine_entry(SINE_IDX_W'(i));
      end
      return t;
   endfunction

endpackage

@@ rtl/sfl_lfo.sv @@
// LFO phase accumulator with registered sine table lookup.
`timescale 1ns / 1ps

module sfl_lfo (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic [sfl_pkg::PHASE_W-1:0]        phase_step,
   output logic signed [sfl_pkg::SINE_W-1:0]  sine
);
   import sfl_pkg::*;

   localparam sine_rom_type SINE_ROM = sine_table();

   logic [PHASE_W-1:0]       phase_ff;
   logic [PHASE_W-1:0]       phase_in;
   logic signed [SINE_W-1:0] sine_ff;

   // sine is sampled at the old phase, then the phase steps
   assign phase_in = advance ? phase_ff + phase_step : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sine_ff <= SINE_ROM[phase_ff[PHASE_W-1 -: SINE_IDX_W]];
      end
   end

   assign sine = sine_ff;

endmodule

@@ rtl/sfl_dly_mem.sv @@
// Delay line memory: one write port, one registered read port.
`timescale 1ns / 1ps

module sfl_dly_mem (
   input  logic                                clock,
   input  sfl_pkg::mem_wr_type                 wr,
   input  logic                                rd_en,
   input  logic [sfl_pkg::ADDR_W-1:0]          rd_addr,
   output logic signed [sfl_pkg::SAMPLE_W-1:0] rd_data
);
   import sfl_pkg::*;

   logic signed [SAMPLE_W-1:0] mem [DELAY_DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sfl_mul.sv @@
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps

module sfl_mul (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [sfl_pkg::MUL_W-1:0]   op_a,
   input  logic signed [sfl_pkg::MUL_W-1:0]   op_b,
   output logic signed [sfl_pkg::PROD_W-1:0]  prod
);
   import sfl_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= op_a * op_b;
      end
   end

   assign prod = prod_ff;

endmodule

@@ rtl/stereo_flanger_unit.sv @@
// Stereo flanger top level: sequencer, pointers, config registers, output stage.
// Sequence: SWING, ADDR, MIX, FIN per accepted item; warm-up items go to FIN.
// FIN registers the result once the output is free; no item is taken until IDLE.
//   Past warm-up the shared multiplier runs twice around one delay memory read.
// Reset (synchronous): pointers, counts, LFO phase and registers go to defaults.
//   The delay memory is not cleared; a fill count makes unwritten entries read 0.
`timescale 1ns / 1ps

module stereo_flanger_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [sfl_pkg::SAMPLE_W-1:0]   req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [sfl_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   input  logic                                  csr_wr_en,
   input  logic [sfl_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sfl_pkg::CSR_DATA_W-1:0]        csr_wr_data
);
   import sfl_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SWING = 3'd1;
   localparam logic [2:0] S_ADDR  = 3'd2;
   localparam logic [2:0] S_MIX   = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;

   localparam int D_W   = DELAY_W + 2;
   localparam int SUM_W = PROD_W + 1;
   localparam int Y_W   = SUM_W - GAIN_FRAC;
   localparam logic signed [Y_W-1:0] Y_MAX = Y_W'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic signed [Y_W-1:0] Y_MIN = ~Y_MAX;
   localparam logic [WARM_W-1:0] WARM_MAX = WARM_W'(4 * ((1 << DELAY_W) - 1));

   // configuration
   logic [DELAY_W-1:0]       base_ff, base_in;
   logic [DELAY_W-1:0]       range_ff, range_in;
   logic signed [GAIN_W-1:0] gain_ff, gain_in;
   logic [PHASE_W-1:0]       step_ff, step_in;

   // control
   logic [2:0]               state_ff, state_in;
   logic [ADDR_W-1:0]        wptr_ff, wptr_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic [WARM_W-1:0]        warm_ff, warm_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // payload
   logic signed [SAMPLE_W-1:0] x_ff;
   logic [ADDR_W-1:0]          cur_ff;
   logic                       bypass_ff;
   logic                       tap_ok_ff;
   logic signed [SAMPLE_W-1:0] out_ff, out_in;

   logic                       accept;
   logic                       out_free;
   logic [WARM_W-1:0]          threshold;
   logic                       warming;

   logic signed [SINE_W-1:0]   sine;
   logic [SINE_W-1:0]          mag_full;
   logic [SINE_FRAC-1:0]       mag;

   logic signed [MUL_W-1:0]    op_a, op_b;
   logic signed [PROD_W-1:0]   prod;
   logic                       mul_en;

   logic [DELAY_W-1:0]         swing;
   logic signed [D_W-1:0]      dsum;
   logic [D_W-2:0]             dpos;
   logic [D_W-1:0]             dist_full;
   logic [ADDR_W-1:0]          tap_dist;
   logic [ADDR_W-1:0]          rd_addr;
   logic                       rd_en;
   logic signed [SAMPLE_W-1:0] mem_q;
   logic signed [SAMPLE_W-1:0] tap;
   mem_wr_type                 mem_wr;

   logic signed [SUM_W-1:0]    sum;
   logic signed [Y_W-1:0]      y_wide;
   logic signed [SAMPLE_W-1:0] y_sat;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign threshold = WARM_W'({(DELAY_W + 1)'(base_ff) + (DELAY_W + 1)'(range_ff), 1'b0});
   assign warming   = (warm_ff < threshold);

   // ---------------- configuration registers ----------------
   always_comb begin
      base_in  = base_ff;
      range_in = range_ff;
      gain_in  = gain_ff;
      step_in  = step_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BASE_DELAY: base_in  = csr_wr_data[DELAY_W-1:0];
            CSR_MOD_RANGE:  range_in = csr_wr_data[DELAY_W-1:0];
            CSR_MIX_GAIN:   gain_in  = csr_wr_data[GAIN_W-1:0];
            CSR_PHASE_STEP: step_in  = csr_wr_data[PHASE_W-1:0];
            default:        ;
         endcase
      end
   end

   // ---------------- LFO, memory, multiplier ----------------
   sfl_lfo u_lfo (
      .clock      (clock),
      .reset      (reset),
      .advance    (accept),
      .phase_step (step_ff),
      .sine       (sine)
   );

   assign mem_wr.en   = accept;
   assign mem_wr.addr = wptr_ff;
   assign mem_wr.data = req_sample_in;

   sfl_dly_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (mem_q)
   );

   assign mag_full = sine[SINE_W-1] ? SINE_W'(-sine) : SINE_W'(sine);
   assign mag      = mag_full[SINE_FRAC-1:0];
   assign tap      = tap_ok_ff ? mem_q : '0;

   always_comb begin
      if (state_ff == S_MIX) begin
         op_a = {{(MUL_W - GAIN_W){gain_ff[GAIN_W-1]}}, gain_ff};
         op_b = {{(MUL_W - SAMPLE_W){tap[SAMPLE_W-1]}}, tap};
      end else begin
         op_a = {{(MUL_W - DELAY_W){1'b0}}, range_ff};
         op_b = {{(MUL_W - SINE_FRAC){1'b0}}, mag};
      end
   end
   assign mul_en = (state_ff == S_SWING) || (state_ff == S_MIX);

   sfl_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // ---------------- tap address ----------------
   assign swing     = prod[SINE_FRAC + DELAY_W - 1 : SINE_FRAC];
   assign dsum      = sine[SINE_W-1]
                      ? $signed({2'b00, base_ff}) - $signed({2'b00, swing})
                      : $signed({2'b00, base_ff}) + $signed({2'b00, swing});
   // negative delay clamps to the current sample
   assign dpos      = dsum[D_W-1] ? '0 : dsum[D_W-2:0];
   assign dist_full = {dpos, 1'b0};
   assign tap_dist  = ADDR_W'(dist_full);
   assign rd_addr   = cur_ff - tap_dist;
   assign rd_en     = (state_ff == S_ADDR);

   // ---------------- mix, round, saturate ----------------
   assign sum    = {{(SUM_W - SAMPLE_W - GAIN_FRAC){x_ff[SAMPLE_W-1]}}, x_ff, {GAIN_FRAC{1'b0}}}
                   + {prod[PROD_W-1], prod}
                   + SUM_W'(1 << (GAIN_FRAC - 1));
   assign y_wide = sum[SUM_W-1:GAIN_FRAC];

   always_comb begin
      if (y_wide > Y_MAX) begin
         y_sat = Y_MAX[SAMPLE_W-1:0];
      end else if (y_wide < Y_MIN) begin
         y_sat = Y_MIN[SAMPLE_W-1:0];
      end else begin
         y_sat = y_wide[SAMPLE_W-1:0];
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      wptr_in      = wptr_ff;
      fill_in      = fill_ff;
      warm_in      = warm_ff;
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               wptr_in = wptr_ff + 1'b1;
               if (fill_ff != FILL_W'(DELAY_DEPTH)) begin
                  fill_in = fill_ff + 1'b1;
               end
               if (warming) begin
                  warm_in  = warm_ff + 1'b1;
                  state_in = S_FIN;
               end else begin
                  state_in = S_SWING;
               end
            end
         end
         S_SWING: state_in = S_ADDR;
         S_ADDR:  state_in = S_MIX;
         S_MIX:   state_in = S_FIN;
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_in       = bypass_ff ? x_ff : y_sat;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wptr_ff      <= '0;
         fill_ff      <= '0;
         warm_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= RST_BASE_DELAY;
         range_ff     <= RST_MOD_RANGE;
         gain_ff      <= RST_MIX_GAIN;
         step_ff      <= RST_PHASE_STEP;
      end else begin
         state_ff     <= state_in;
         wptr_ff      <= wptr_in;
         fill_ff      <= fill_in;
         warm_ff      <= warm_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         range_ff     <= range_in;
         gain_ff      <= gain_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (accept) begin
         x_ff      <= req_sample_in;
         cur_ff    <= wptr_ff;
         bypass_ff <= warming;
      end
      // entries as far back as the fill count or farther were never written
      if (state_ff == S_ADDR) begin
         tap_ok_ff <= ({1'b0, tap_dist} < fill_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = out_ff;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(DELAY_DEPTH))
      else $error("fill count beyond memory depth");

   a_warm_bound: assert property (@(posedge clock) disable iff (reset)
      warm_ff <= WARM_MAX)
      else $error("warm-up count beyond largest threshold");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("input taken again right after an item");

   a_mix_before_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) && !bypass_ff && $changed(state_ff) |-> $past(state_ff) == S_MIX)
      else $error("mixed result without multiply pass");
`endif

endmodule
